// ===== hw/rtl/mldv_pkg.sv =====
// ----------------------------------------------------------------------------
// mldv_pkg
// Shared types, constants and helper functions for the mouse-look direction
// vector unit: angle ranges, state encoding, reciprocal table for the Taylor
// series divisions and the output rounding function.
// ----------------------------------------------------------------------------
`default_nettype none

package mldv_pkg;

  // field widths
  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 15;
  localparam int OUT_BITS        = OUT_FRAC_BITS + 1;
  localparam int SENS_BITS       = 16;

  // internal widths
  localparam int DELTA_BITS = COORD_BITS + SENS_BITS + 1;  // signed scaled delta
  localparam int ACC_BITS   = 30;                          // yaw / pitch sums
  localparam int YAW_BITS   = 25;                          // [-180, 180) degrees
  localparam int PITCH_BITS = 24;                          // [-89, 89] degrees
  localparam int ANG_BITS   = 25;                          // [0, 360) degrees
  localparam int FOLD_BITS  = 22;                          // [0, 45] degrees
  localparam int Q30_BITS   = 30;                          // values below 1.0
  localparam int MAG_BITS   = 31;                          // values up to 1.0
  localparam int MUL_BITS   = 32;
  localparam int PROD_BITS  = 2 * MUL_BITS;

  localparam int ANG_SCALE = 1 << ANGLE_FRAC_BITS;

  // reset values
  localparam logic [SENS_BITS-1:0]  SENS_RESET   = SENS_BITS'(3277);
  localparam logic [COORD_BITS-1:0] LAST_X_RESET = COORD_BITS'(683);
  localparam logic [COORD_BITS-1:0] LAST_Y_RESET = COORD_BITS'(384);
  localparam logic signed [YAW_BITS-1:0] YAW_RESET = YAW_BITS'(-90 * ANG_SCALE);

  // angle constants
  localparam logic signed [ACC_BITS-1:0]   ACC_FULL  = ACC_BITS'(360 * ANG_SCALE);
  localparam logic signed [ACC_BITS-1:0]   ACC_HALF  = ACC_BITS'(180 * ANG_SCALE);
  localparam logic signed [ACC_BITS-1:0]   ACC_LIM   = ACC_BITS'(89 * ANG_SCALE);
  localparam logic signed [PITCH_BITS-1:0] PITCH_LIM = PITCH_BITS'(89 * ANG_SCALE);
  localparam logic signed [YAW_BITS-1:0]   YAW_HALF  = YAW_BITS'(180 * ANG_SCALE);
  localparam logic signed [ANG_BITS:0]     ANG_FULL  = (ANG_BITS + 1)'(360 * ANG_SCALE);
  localparam logic [ANG_BITS-1:0] ANG_Q45  = ANG_BITS'(45 * ANG_SCALE);
  localparam logic [ANG_BITS-1:0] ANG_Q90  = ANG_BITS'(90 * ANG_SCALE);
  localparam logic [ANG_BITS-1:0] ANG_Q180 = ANG_BITS'(180 * ANG_SCALE);
  localparam logic [ANG_BITS-1:0] ANG_Q270 = ANG_BITS'(270 * ANG_SCALE);

  // pi/180 in Q.30 and half an lsb of the degree fraction
  localparam logic [MUL_BITS-1:0]  DEG_TO_RAD = MUL_BITS'(18740330);
  localparam logic [PROD_BITS-1:0] RAD_RND    = PROD_BITS'(ANG_SCALE / 2);
  localparam logic [MAG_BITS-1:0]  ONE_Q30    = MAG_BITS'(1) << Q30_BITS;

  // series has eight divided steps and sixteen steps in all per angle pass
  localparam logic [3:0] POLY_SIN_END = 4'd7;
  localparam logic [3:0] POLY_LAST    = 4'd15;

  // rounding shifts for Q.60 products and Q.30 terms
  localparam int SHIFT_Q60 = 60 - OUT_FRAC_BITS;
  localparam int SHIFT_Q30 = 30 - OUT_FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_X,
    ST_YAW_MOD,
    ST_SCALE_Y,
    ST_ANG_POS,
    ST_ANG_QUAD,
    ST_ANG_FOLD,
    ST_RAD,
    ST_SQR,
    ST_POLY,
    ST_OUT_X,
    ST_OUT_Z
  } mldv_state_t;

  // reciprocal multiplier and shift giving floor(v / c) exactly for v < 2^30
  typedef struct packed {
    logic [MAG_BITS-1:0] mult;
    logic [5:0]          shift;
  } mldv_recip_t;

  function automatic mldv_recip_t recip_lookup(input logic [2:0] idx);
    mldv_recip_t r;
    unique case (idx)
      3'd0: r = '{mult: MAG_BITS'(1908874354), shift: 6'd37};  // 72
      3'd1: r = '{mult: MAG_BITS'(1636178018), shift: 6'd36};  // 42
      3'd2: r = '{mult: MAG_BITS'(1717986919), shift: 6'd35};  // 20
      3'd3: r = '{mult: MAG_BITS'(1431655766), shift: 6'd33};  // 6
      3'd4: r = '{mult: MAG_BITS'(1527099484), shift: 6'd37};  // 90
      3'd5: r = '{mult: MAG_BITS'(1227133514), shift: 6'd36};  // 56
      3'd6: r = '{mult: MAG_BITS'(1145324613), shift: 6'd35};  // 30
      3'd7: r = '{mult: MAG_BITS'(1431655766), shift: 6'd34};  // 12
    endcase
    return r;
  endfunction

  // round magnitude half away from zero, saturate, return two's complement
  function automatic logic [OUT_BITS-1:0] out_round(input logic [PROD_BITS-1:0] mag,
                                                     input logic neg,
                                                     input int unsigned shift);
    logic [PROD_BITS:0] sum;
    logic [PROD_BITS:0] v;
    logic [PROD_BITS:0] lim;
    logic [PROD_BITS:0] neg_v;
    sum = {1'b0, mag} + ((PROD_BITS + 1)'(1) << (shift - 1));
    v   = sum >> shift;
    lim = (PROD_BITS + 1)'(1) << OUT_FRAC_BITS;
    if (!neg) begin
      if (v > lim - 1'b1) v = lim - 1'b1;
      neg_v = v;
    end else begin
      if (v > lim) v = lim;
      neg_v = '0 - v;
    end
    return neg_v[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mouse_look_direction_vector_unit.sv =====
// ----------------------------------------------------------------------------
// mouse_look_direction_vector_unit
// Yaw/pitch camera from pointer positions: accumulates scaled pointer deltas
// into yaw and pitch and returns the unit front vector in signed Q1.15.
// ----------------------------------------------------------------------------
// One pointer beat in gives one direction beat out. The first beat after
// reset only loads the stored position, so it turns nothing, but still returns
// the vector for the current angles (yaw -90, pitch 0 after reset). All
// multiplications run through one 32x32 multiplier under a step sequencer: delta
// scaling, degree-to-radian conversion, a 16-step Horner series per angle and
// the two output products. The time from acceptance to a valid result grows
// with the yaw wrap, which adds or removes one turn per cycle, and with any
// output stall. in_tready is high only while the sequencer is idle. The
// result sits in an output register, so the next beat may be taken while the
// previous result still waits; the sequencer holds before its final load
// until that register is free. Write cfg_wdata with cfg_we only while idle.
`default_nettype none

module mouse_look_direction_vector_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // pointer_x [11:0], pointer_y [23:12]
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [2*mldv_pkg::COORD_BITS-1:0] in_tdata,
  // front_x [15:0], front_y [31:16], front_z [47:32]
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [3*mldv_pkg::OUT_BITS-1:0]     out_tdata,
  // sensitivity, degrees per pixel with 16 fractional bits
  input  wire logic                           cfg_we,
  input  wire logic [mldv_pkg::SENS_BITS-1:0] cfg_wdata
);

  import mldv_pkg::*;

  mldv_state_t state_r, state_nxt;

  // architectural state
  logic [SENS_BITS-1:0]         sens_r;
  logic [COORD_BITS-1:0]        last_x_r, last_y_r;
  logic                         first_r;
  logic signed [YAW_BITS-1:0]   yaw_r;
  logic signed [PITCH_BITS-1:0] pitch_r;

  // per-item work registers
  logic                         dx_neg_r, dy_neg_r;
  logic [COORD_BITS-1:0]        dx_mag_r, dy_mag_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic                         pass_r;
  logic [ANG_BITS-1:0]          ang_r;
  logic [1:0]                   quad_r;
  logic                         swap_r;
  logic [Q30_BITS-1:0]          x_r, x2_r, p_r, sp_r;
  logic [MAG_BITS-1:0]          t_r;
  logic [3:0]                   step_r;
  logic [MAG_BITS-1:0]          sy_mag_r, cy_mag_r, ps_mag_r, pc_mag_r;
  logic                         sy_neg_r, cy_neg_r, ps_neg_r, pc_neg_r;
  logic [OUT_BITS-1:0]          fx_r;
  logic [3*OUT_BITS-1:0]        out_data_r;
  logic                         out_valid_r;

  // shared multiplier
  logic [MUL_BITS-1:0]  mul_a, mul_b;
  logic [PROD_BITS-1:0] prod;

  logic [COORD_BITS-1:0]        px, py, base_x, base_y;
  logic signed [COORD_BITS:0]   dx, dy;
  logic                         cur_neg;
  logic [DELTA_BITS-2:0]        d_mag;
  logic signed [DELTA_BITS-1:0] delta_s;
  logic signed [ACC_BITS-1:0]   psum;
  logic                         acc_in_range;
  logic signed [YAW_BITS-1:0]   ang_src;
  logic signed [ANG_BITS:0]     ang_ext;
  mldv_recip_t                  recip;
  logic [PROD_BITS-1:0]         quo, rad_sum;
  logic [MAG_BITS-1:0]          cp_full, s_base, c_base;
  logic [MAG_BITS-1:0]          sc_s_mag, sc_c_mag;
  logic                         sc_s_neg, sc_c_neg;
  logic                         in_acc, out_load;

  assign prod = mul_a * mul_b;

  // input unpack and deltas, first beat turns nothing
  assign px     = in_tdata[COORD_BITS-1:0];
  assign py     = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign base_x = first_r ? px : last_x_r;
  assign base_y = first_r ? py : last_y_r;
  assign dx     = $signed({1'b0, px}) - $signed({1'b0, base_x});
  assign dy     = $signed({1'b0, base_y}) - $signed({1'b0, py});

  // signed scaled delta from the shared product
  assign cur_neg = (state_r == ST_SCALE_Y) ? dy_neg_r : dx_neg_r;
  assign d_mag   = prod[DELTA_BITS-2:0];
  assign delta_s = cur_neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
  assign psum    = ACC_BITS'(pitch_r) + ACC_BITS'(delta_s);

  assign acc_in_range = !acc_r[ACC_BITS-1] && (acc_r < ACC_FULL);

  // angle for the current pass, brought into [0, 360)
  assign ang_src = pass_r ? YAW_BITS'(pitch_r) : yaw_r;
  assign ang_ext = (ANG_BITS + 1)'(ang_src) + ANG_FULL;

  // series step helpers
  assign recip   = recip_lookup(step_r[3:1]);
  assign quo     = prod >> recip.shift;
  assign rad_sum = prod + RAD_RND;
  assign cp_full = ONE_Q30 - {1'b0, prod[60:31]};

  // undo the fold and the quadrant reduction
  assign s_base = swap_r ? cp_full : {1'b0, sp_r};
  assign c_base = swap_r ? {1'b0, sp_r} : cp_full;

  always_comb begin
    case (quad_r)
      2'd0: begin
        sc_s_mag = s_base; sc_s_neg = 1'b0; sc_c_mag = c_base; sc_c_neg = 1'b0;
      end
      2'd1: begin
        sc_s_mag = c_base; sc_s_neg = 1'b0; sc_c_mag = s_base; sc_c_neg = 1'b1;
      end
      2'd2: begin
        sc_s_mag = s_base; sc_s_neg = 1'b1; sc_c_mag = c_base; sc_c_neg = 1'b1;
      end
      default: begin
        sc_s_mag = c_base; sc_s_neg = 1'b1; sc_c_mag = s_base; sc_c_neg = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_SCALE_X;
      ST_SCALE_X:  state_nxt = ST_YAW_MOD;
      ST_YAW_MOD:  if (acc_in_range) state_nxt = ST_SCALE_Y;
      ST_SCALE_Y:  state_nxt = ST_ANG_POS;
      ST_ANG_POS:  state_nxt = ST_ANG_QUAD;
      ST_ANG_QUAD: state_nxt = ST_ANG_FOLD;
      ST_ANG_FOLD: state_nxt = ST_RAD;
      ST_RAD:      state_nxt = ST_SQR;
      ST_SQR:      state_nxt = ST_POLY;
      ST_POLY: begin
        if (step_r == POLY_LAST) state_nxt = pass_r ? ST_OUT_X : ST_ANG_POS;
      end
      ST_OUT_X:    state_nxt = ST_OUT_Z;
      ST_OUT_Z:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_SCALE_X: begin
        mul_a = MUL_BITS'(dx_mag_r);
        mul_b = MUL_BITS'(sens_r);
      end
      ST_SCALE_Y: begin
        mul_a = MUL_BITS'(dy_mag_r);
        mul_b = MUL_BITS'(sens_r);
      end
      ST_RAD: begin
        mul_a = MUL_BITS'(ang_r[FOLD_BITS-1:0]);
        mul_b = DEG_TO_RAD;
      end
      ST_SQR: begin
        mul_a = MUL_BITS'(x_r);
        mul_b = MUL_BITS'(x_r);
      end
      ST_POLY: begin
        if (!step_r[0]) begin
          mul_a = (step_r[2:0] == 3'd0) ? MUL_BITS'(x2_r) : MUL_BITS'(p_r);
          mul_b = MUL_BITS'(recip.mult);
        end else begin
          mul_a = (step_r == POLY_SIN_END) ? MUL_BITS'(x_r) : MUL_BITS'(x2_r);
          mul_b = MUL_BITS'(t_r);
        end
      end
      ST_OUT_X: begin
        mul_a = MUL_BITS'(cy_mag_r);
        mul_b = MUL_BITS'(pc_mag_r);
      end
      ST_OUT_Z: begin
        mul_a    = MUL_BITS'(sy_mag_r);
        mul_b    = MUL_BITS'(pc_mag_r);
        out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sens_r      <= SENS_RESET;
      last_x_r    <= LAST_X_RESET;
      last_y_r    <= LAST_Y_RESET;
      first_r     <= 1'b1;
      yaw_r       <= YAW_RESET;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sens_r <= cfg_wdata;
      // input beat: new last position
      if (in_acc) begin
        last_x_r <= px;
        last_y_r <= py;
        first_r  <= 1'b0;
      end
      // yaw wrap, one turn per cycle
      if (state_r == ST_YAW_MOD && acc_in_range) yaw_r <= YAW_BITS'(acc_r - ACC_HALF);
      // pitch add and clamp
      if (state_r == ST_SCALE_Y) begin
        if (psum > ACC_LIM)       pitch_r <= PITCH_LIM;
        else if (psum < -ACC_LIM) pitch_r <= -PITCH_LIM;
        else                      pitch_r <= PITCH_BITS'(psum);
      end
      // output register
      if (out_load)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath work registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dx_neg_r <= dx[COORD_BITS];
        dx_mag_r <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        dy_neg_r <= dy[COORD_BITS];
        dy_mag_r <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      end
      ST_SCALE_X: acc_r <= ACC_BITS'(yaw_r) + ACC_BITS'(delta_s) + ACC_HALF;
      ST_YAW_MOD: begin
        if (acc_r[ACC_BITS-1])    acc_r <= acc_r + ACC_FULL;
        else if (!acc_in_range)   acc_r <= acc_r - ACC_FULL;
      end
      ST_SCALE_Y: pass_r <= 1'b0;
      ST_ANG_POS: ang_r <= ang_src[YAW_BITS-1] ? ang_ext[ANG_BITS-1:0] : ANG_BITS'(ang_src);
      // quadrant and remainder
      ST_ANG_QUAD: begin
        if (ang_r >= ANG_Q270) begin
          quad_r <= 2'd3;
          ang_r  <= ang_r - ANG_Q270;
        end else if (ang_r >= ANG_Q180) begin
          quad_r <= 2'd2;
          ang_r  <= ang_r - ANG_Q180;
        end else if (ang_r >= ANG_Q90) begin
          quad_r <= 2'd1;
          ang_r  <= ang_r - ANG_Q90;
        end else begin
          quad_r <= 2'd0;
        end
      end
      // fold onto [0, 45] degrees
      ST_ANG_FOLD: begin
        swap_r <= ang_r > ANG_Q45;
        if (ang_r > ANG_Q45) ang_r <= ANG_Q90 - ang_r;
      end
      ST_RAD: x_r <= rad_sum[ANGLE_FRAC_BITS +: Q30_BITS];
      ST_SQR: begin
        x2_r   <= prod[2*Q30_BITS-1:Q30_BITS];
        step_r <= '0;
      end
      // horner series: even steps divide, odd steps multiply
      ST_POLY: begin
        step_r <= step_r + 1'b1;
        if (!step_r[0]) begin
          t_r <= ONE_Q30 - {1'b0, quo[Q30_BITS-1:0]};
        end else if (step_r == POLY_SIN_END) begin
          sp_r <= prod[2*Q30_BITS-1:Q30_BITS];
        end else if (step_r == POLY_LAST) begin
          if (!pass_r) begin
            sy_mag_r <= sc_s_mag;
            sy_neg_r <= sc_s_neg;
            cy_mag_r <= sc_c_mag;
            cy_neg_r <= sc_c_neg;
            pass_r   <= 1'b1;
          end else begin
            ps_mag_r <= sc_s_mag;
            ps_neg_r <= sc_s_neg;
            pc_mag_r <= sc_c_mag;
            pc_neg_r <= sc_c_neg;
          end
        end else begin
          p_r <= prod[2*Q30_BITS-1:Q30_BITS];
        end
      end
      ST_OUT_X: fx_r <= out_round(prod, cy_neg_r ^ pc_neg_r, SHIFT_Q60);
      ST_OUT_Z: begin
        if (out_load) begin
          out_data_r <= {out_round(prod, sy_neg_r ^ pc_neg_r, SHIFT_Q60),
                         out_round(PROD_BITS'(ps_mag_r), ps_neg_r, SHIFT_Q30),
                         fx_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= PITCH_LIM) && (pitch_r >= -PITCH_LIM))
    else $error("pitch outside +-89 degrees");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r >= -YAW_HALF) && (yaw_r < YAW_HALF))
    else $error("yaw outside [-180, 180) degrees");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCALE_X))
    else $error("accepted beat did not start the sequencer");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_OUT_Z))
    else $error("result beat raised outside the final step");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse-look direction vector unit. Pointer beats
// go in from a queue in random bursts, and the result channel stalls in
// shifting patterns. Every accepted beat runs through a local yaw/pitch
// camera predictor with its own Taylor-series sine and cosine. Each result
// beat is checked field by field against the oldest predicted vector.
// Sensitivity is rewritten between phases, and only while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COORD_W   = mldv_pkg::COORD_BITS;
  localparam int OUT_W     = mldv_pkg::OUT_BITS;
  localparam int SENS_W    = mldv_pkg::SENS_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // angles in degrees with 16 fractional bits
  localparam longint ANG_ONE   = 64'sd65536;
  localparam longint ANG_FULL  = 360 * ANG_ONE;
  localparam longint ANG_HALF  = 180 * ANG_ONE;
  localparam longint ANG_Q90   = 90 * ANG_ONE;
  localparam longint ANG_Q45   = 45 * ANG_ONE;
  localparam longint PITCH_MAX = 89 * ANG_ONE;
  localparam longint unsigned UNIT_Q30   = 64'd1 << 30;
  localparam longint unsigned DEG_TO_RAD = 64'd18740330;
  localparam logic [SENS_W-1:0] SENS_DEFAULT = 16'd3277;
  // exactly 90 degrees for a 1024 pixel move
  localparam logic [SENS_W-1:0] SENS_QUARTER = 16'd5760;

  typedef struct {
    logic signed [OUT_W-1:0] front_x;
    logic signed [OUT_W-1:0] front_y;
    logic signed [OUT_W-1:0] front_z;
  } front_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*COORD_W-1:0] in_tdata = '0;     // pointer_x, pointer_y
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OUT_W-1:0] out_tdata;           // front_x, front_y, front_z
  logic cfg_we = 1'b0;
  logic [SENS_W-1:0] cfg_wdata = '0;

  // pending pointer beats and predicted direction vectors
  logic [2*COORD_W-1:0] pointer_q[$];
  front_vec_t front_q[$];

  // camera state of the predictor
  logic [COORD_W-1:0] cam_last_x;
  logic [COORD_W-1:0] cam_last_y;
  bit cam_first;
  longint cam_yaw;
  longint cam_pitch;
  longint unsigned cam_sens;

  int mismatches = 0;
  int idle_cycles = 0;
  bit in_beat_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int walk_x = 683;
  int walk_y = 384;

  mouse_look_direction_vector_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // pixel delta times sensitivity, sign kept on the magnitude
  function automatic longint turn_of_delta(input longint d);
    longint unsigned mag;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    mag = mag * cam_sens;
    return (d < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // sine and cosine in Q.30 from quadrant folding and Horner series
  function automatic void sin_cos_q30(input longint ang, output longint s, output longint c);
    longint a;
    longint quad;
    longint unsigned r, x, x2, t, sp, cp;
    bit swap;
    a = ang % ANG_FULL;
    if (a < 0) a += ANG_FULL;
    quad = a / ANG_Q90;
    r = a - quad * ANG_Q90;
    swap = r > ANG_Q45;
    if (swap) r = ANG_Q90 - r;
    x  = (r * DEG_TO_RAD + 64'd32768) >> 16;
    x2 = (x * x) >> 30;
    // sine to the ninth power
    t  = UNIT_Q30 - x2 / 72;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 42;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 20;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 6;
    sp = (x * t) >> 30;
    // cosine to the tenth power
    t  = UNIT_Q30 - x2 / 90;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 56;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 30;
    t  = UNIT_Q30 - ((x2 * t) >> 30) / 12;
    cp = UNIT_Q30 - ((x2 * t) >> 30) / 2;
    if (swap) begin
      t  = sp;
      sp = cp;
      cp = t;
    end
    case (quad)
      0: begin
        s = longint'(sp);
        c = longint'(cp);
      end
      1: begin
        s = longint'(cp);
        c = -longint'(sp);
      end
      2: begin
        s = -longint'(sp);
        c = -longint'(cp);
      end
      default: begin
        s = -longint'(cp);
        c = longint'(sp);
      end
    endcase
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // round half away from zero, saturate +1.0, back to two's complement
  function automatic logic signed [OUT_W-1:0] round_to_q15(input longint unsigned mag,
                                                            input bit neg,
                                                            input int shift);
    longint unsigned v;
    longint unsigned lim;
    lim = 64'd1 << (OUT_W - 1);
    v = (mag + (64'd1 << (shift - 1))) >> shift;
    if (!neg) return (v > lim - 1) ? OUT_W'(lim - 1) : OUT_W'(v);
    if (v > lim) v = lim;
    return OUT_W'(64'd0 - v);
  endfunction

  // advance the camera by one pointer position and build the front vector
  function automatic front_vec_t predict_front(input logic [COORD_W-1:0] px,
                                               input logic [COORD_W-1:0] py);
    longint dx, dy, y, sy, cy, sp, cp;
    front_vec_t f;
    if (cam_first) begin
      cam_last_x = px;
      cam_last_y = py;
      cam_first = 1'b0;
    end
    dx = longint'(px) - longint'(cam_last_x);
    dy = longint'(cam_last_y) - longint'(py);
    cam_last_x = px;
    cam_last_y = py;
    // yaw wraps into [-180, 180)
    y = (cam_yaw + turn_of_delta(dx) + ANG_HALF) % ANG_FULL;
    if (y < 0) y += ANG_FULL;
    cam_yaw = y - ANG_HALF;
    // pitch clamps at +-89
    cam_pitch += turn_of_delta(dy);
    if (cam_pitch > PITCH_MAX) cam_pitch = PITCH_MAX;
    if (cam_pitch < -PITCH_MAX) cam_pitch = -PITCH_MAX;
    sin_cos_q30(cam_yaw, sy, cy);
    sin_cos_q30(cam_pitch, sp, cp);
    f.front_x = round_to_q15(magnitude(cy) * magnitude(cp), (cy < 0) != (cp < 0),
                             60 - (OUT_W - 1));
    f.front_y = round_to_q15(magnitude(sp), sp < 0, 30 - (OUT_W - 1));
    f.front_z = round_to_q15(magnitude(sy) * magnitude(cp), (sy < 0) != (cp < 0),
                             60 - (OUT_W - 1));
    return f;
  endfunction

  function automatic void queue_pointer(input int px, input int py);
    pointer_q.push_back({COORD_W'(py), COORD_W'(px)});
  endfunction

  // mostly small pointer moves, plus jumps, screen edges and repeats
  function automatic void queue_random_pointer();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      walk_x += int'($urandom_range(0, 128)) - 64;
      walk_y += int'($urandom_range(0, 128)) - 64;
      if (walk_x < 0) walk_x = 0;
      if (walk_x > COORD_MAX) walk_x = COORD_MAX;
      if (walk_y < 0) walk_y = 0;
      if (walk_y > COORD_MAX) walk_y = COORD_MAX;
    end else if (k < 85) begin
      walk_x = $urandom_range(0, COORD_MAX);
      walk_y = $urandom_range(0, COORD_MAX);
    end else if (k < 95) begin
      walk_x = $urandom_range(0, 1) ? COORD_MAX : 0;
      walk_y = $urandom_range(0, 1) ? COORD_MAX : 0;
    end
    queue_pointer(walk_x, walk_y);
  endfunction

  // wait until every queued beat has gone in and its result has come out;
  // checked at the rising edge, where queue and in_tvalid agree
  task automatic wait_idle();
    while (pointer_q.size() != 0 || in_tvalid || front_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sensitivity(input logic [SENS_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cam_sens = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reset, directed phases, random phases, final check
  initial begin
    cam_last_x = COORD_W'(683);
    cam_last_y = COORD_W'(384);
    cam_first = 1'b1;
    cam_yaw = -90 * ANG_ONE;
    cam_pitch = 0;
    cam_sens = SENS_DEFAULT;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // quarter turns: yaw -90, 0, 90, wrap to -180, then pitch to both limits
    write_sensitivity(SENS_QUARTER);
    queue_pointer(0, 384);
    queue_pointer(1024, 384);
    queue_pointer(2048, 384);
    queue_pointer(3072, 384);
    queue_pointer(3072, 0);
    queue_pointer(3072, COORD_MAX);
    queue_pointer(3072, 0);
    queue_pointer(0, COORD_MAX);
    queue_pointer(COORD_MAX, 0);
    queue_pointer(0, 0);
    queue_pointer(COORD_MAX, COORD_MAX);
    queue_pointer(2048, 2048);
    wait_idle();

    // full sensitivity with full-screen jumps, many turns per beat
    write_sensitivity('1);
    queue_pointer(0, 0);
    queue_pointer(COORD_MAX, COORD_MAX);
    queue_pointer(0, COORD_MAX);
    queue_pointer(COORD_MAX, 0);
    queue_pointer(1, 1);
    queue_pointer(COORD_MAX - 1, COORD_MAX - 1);
    wait_idle();

    // zero sensitivity, nothing turns
    write_sensitivity('0);
    queue_pointer(123, 456);
    queue_pointer(COORD_MAX, 0);
    wait_idle();

    // smallest nonzero sensitivity
    write_sensitivity(16'd1);
    queue_pointer(0, 0);
    queue_pointer(1, COORD_MAX);
    queue_pointer(COORD_MAX, 0);
    wait_idle();

    // random phases under changing sensitivity
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: write_sensitivity(SENS_DEFAULT);
        1: write_sensitivity($urandom_range(0, 65535));
        2: write_sensitivity($urandom_range(1, 6000));
        default: write_sensitivity($urandom_range(0, 1) ? '1 : '0);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_pointer();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && front_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // pointer driver: bursts of random length separated by random gaps
  always @(negedge clk) begin : pointer_drive
    logic nxt_valid;
    logic [2*COORD_W-1:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data = in_tdata;
    if (in_beat_taken) begin
      in_beat_taken = 1'b0;
      nxt_valid = 1'b0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      end
    end
    if (!nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pointer_q.size() != 0) begin
        nxt_data = pointer_q.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata <= nxt_data;
  end

  // result backpressure: always ready, coin flips, or long stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // monitor: predict on input beats, check output beats, watchdog
  always @(posedge clk) begin : beat_monitor
    front_vec_t want;
    logic signed [OUT_W-1:0] got_x, got_y, got_z;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        front_q.push_back(predict_front(in_tdata[COORD_W-1:0],
                                        in_tdata[2*COORD_W-1:COORD_W]));
        in_beat_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got_x = out_tdata[OUT_W-1:0];
        got_y = out_tdata[2*OUT_W-1:OUT_W];
        got_z = out_tdata[3*OUT_W-1:2*OUT_W];
        if (front_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected direction beat: expected none, actual %0d %0d %0d",
                   $time, got_x, got_y, got_z);
        end else begin
          want = front_q.pop_front();
          if (got_x !== want.front_x) begin
            mismatches++;
            $display("%0t front_x mismatch: expected %0d, actual %0d",
                     $time, want.front_x, got_x);
          end
          if (got_y !== want.front_y) begin
            mismatches++;
            $display("%0t front_y mismatch: expected %0d, actual %0d",
                     $time, want.front_y, got_y);
          end
          if (got_z !== want.front_z) begin
            mismatches++;
            $display("%0t front_z mismatch: expected %0d, actual %0d",
                     $time, want.front_z, got_z);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

endmodule
